@@ hdl/ptgr_pkg.sv @@
// ----------------------------------------------------------------------------
// ptgr_pkg
// Shared constants and helpers for the planar tile to gray raster decoder.
// ----------------------------------------------------------------------------
package ptgr_pkg;

  localparam int unsigned TileRows       = 8;
  localparam int unsigned TileBytes      = 16;
  localparam int unsigned RowAw          = $clog2(TileRows);
  localparam int unsigned ByteCntW       = $clog2(TileBytes);
  localparam int unsigned ByteW          = 8;
  localparam int unsigned AddrW          = 16;
  localparam int unsigned TprW           = 7;
  localparam int unsigned ColW           = 6;
  localparam int unsigned MaxCols        = 64;
  localparam int unsigned MaxTilesDef    = 512;
  localparam logic [TprW-1:0] TprReset   = TprW'(50);
  localparam logic [ByteW-1:0] GrayStep  = 8'h55;

  typedef logic [ByteW-1:0] pixel_t;

  // two plane bits -> gray level (0x00, 0x55, 0xaa, 0xff)
  function automatic pixel_t gray_level(input logic hi, input logic lo);
    logic [ByteW+1:0] prod;
    prod = {{ByteW{1'b0}}, hi, lo} * {2'b00, GrayStep};
    return prod[ByteW-1:0];
  endfunction

endpackage

@@ hdl/ptgr_intf.sv @@
// ----------------------------------------------------------------------------
// ptgr_intf
// Valid/ready channels: tile byte words in, gray raster row words out.
// ----------------------------------------------------------------------------
interface ptgr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] chr_byte;
  logic       restart;

  modport source (output valid, output chr_byte, output restart, input ready);
  modport sink   (input valid, input chr_byte, input restart, output ready);
endinterface

interface ptgr_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_address;
  logic [7:0]  pixel_0;
  logic [7:0]  pixel_1;
  logic [7:0]  pixel_2;
  logic [7:0]  pixel_3;
  logic [7:0]  pixel_4;
  logic [7:0]  pixel_5;
  logic [7:0]  pixel_6;
  logic [7:0]  pixel_7;

  modport source (output valid, output pixel_address, output pixel_0, output pixel_1,
                  output pixel_2, output pixel_3, output pixel_4, output pixel_5,
                  output pixel_6, output pixel_7, input ready);
  modport sink   (input valid, input pixel_address, input pixel_0, input pixel_1,
                  input pixel_2, input pixel_3, input pixel_4, input pixel_5,
                  input pixel_6, input pixel_7, output ready);
endinterface

@@ hdl/planar_tile_to_gray_raster.sv @@
// ----------------------------------------------------------------------------
// planar_tile_to_gray_raster
// Decodes 2bpp planar tile bytes into rows of eight gray pixels with the
// image address of each row's leftmost pixel.
//
//   channel    dir  handshake        word
//   chr_i      in   valid/ready      chr_byte, restart
//   pix_o      out  valid/ready      pixel_address, pixel_0..pixel_7
//   cfg        in   write enable     tiles_per_row
//
// One byte per cycle sustained while pix_o is not stalled. A high-plane byte
// goes through the low-plane row memory read and the output register.
// rst_ni clears counters and valids and sets tiles_per_row to 50; row memory
// is not cleared. A stalled output fills the read stage, then chr_i.ready drops.
// ----------------------------------------------------------------------------
module planar_tile_to_gray_raster #(
  parameter int unsigned MAX_TILES = ptgr_pkg::MaxTilesDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      tiles_per_row_we_i,
  input  logic [ptgr_pkg::TprW-1:0] tiles_per_row_i,
  ptgr_in_if.sink                   chr_i,
  ptgr_out_if.source                pix_o
);
  import ptgr_pkg::*;

  localparam int unsigned TdW = $clog2(MAX_TILES + 1);

  // config
  logic [TprW-1:0] tpr_q;
  logic [TprW-1:0] cols;

  // counters
  logic [ByteCntW-1:0] byte_q, byte_d, byte_eff;
  logic [ColW-1:0]     col_q, col_d, col_eff;
  logic [AddrW-1:0]    base_q, base_d, base_eff;
  logic [TdW-1:0]      done_q, done_d, done_eff;

  // low-plane row memory
  logic [ByteW-1:0] low_mem [TileRows];
  logic             wr_en, rd_en;
  logic [RowAw-1:0] row_idx;
  logic [ByteW-1:0] low_rd_q;

  // read stage
  logic             s1_valid_q;
  logic [ByteW-1:0] s1_hi_q;
  logic [AddrW-1:0] s1_addr_q;
  logic [AddrW-1:0] addr_d;
  logic             s1_adv;

  // output register
  logic             out_valid_q;
  logic [AddrW-1:0] out_addr_q;
  pixel_t           out_pix_q [TileRows];

  logic             accept, active, high_plane, tile_end;
  logic [9:0]       cols_x_row;

  always_comb begin
    if (tpr_q == '0) begin
      cols = TprW'(1);
    end else if (tpr_q > TprW'(MaxCols)) begin
      cols = TprW'(MaxCols);
    end else begin
      cols = tpr_q;
    end
  end

  assign s1_adv      = !out_valid_q || pix_o.ready;
  assign chr_i.ready = !s1_valid_q || s1_adv;
  assign accept      = chr_i.valid && chr_i.ready;

  assign byte_eff = chr_i.restart ? '0 : byte_q;
  assign col_eff  = chr_i.restart ? '0 : col_q;
  assign base_eff = chr_i.restart ? '0 : base_q;
  assign done_eff = chr_i.restart ? '0 : done_q;

  assign active     = done_eff < TdW'(MAX_TILES);
  assign high_plane = byte_eff[ByteCntW-1];
  assign row_idx    = byte_eff[RowAw-1:0];
  assign tile_end   = byte_eff == ByteCntW'(TileBytes - 1);
  assign wr_en      = accept && active && !high_plane;
  assign rd_en      = accept && active && high_plane;

  assign cols_x_row = 10'(cols) * 10'(row_idx);
  assign addr_d     = base_eff + AddrW'({col_eff, 3'b000}) + AddrW'({cols_x_row, 3'b000});

  always_comb begin
    byte_d = byte_eff;
    col_d  = col_eff;
    base_d = base_eff;
    done_d = done_eff;
    if (active) begin
      byte_d = byte_eff + ByteCntW'(1);
      if (high_plane && tile_end) begin
        byte_d = '0;
        done_d = done_eff + TdW'(1);
        if ({1'b0, col_eff} + TprW'(1) >= cols) begin
          col_d  = '0;
          base_d = base_eff + AddrW'({cols, 6'b000000});
        end else begin
          col_d = col_eff + ColW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpr_q  <= TprReset;
      byte_q <= '0;
      col_q  <= '0;
      base_q <= '0;
      done_q <= '0;
    end else begin
      if (tiles_per_row_we_i) begin
        tpr_q <= tiles_per_row_i;
      end
      if (accept) begin
        byte_q <= byte_d;
        col_q  <= col_d;
        base_q <= base_d;
        done_q <= done_d;
      end
    end
  end

  // high row k is read at least eight words after low row k is written
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      low_mem[row_idx] <= chr_i.chr_byte;
    end
    if (rd_en) begin
      low_rd_q <= low_mem[row_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (chr_i.ready) begin
        s1_valid_q <= rd_en;
      end
      if (s1_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      s1_hi_q   <= chr_i.chr_byte;
      s1_addr_q <= addr_d;
    end
    if (s1_adv && s1_valid_q) begin
      out_addr_q <= s1_addr_q;
      for (int k = 0; k < TileRows; k++) begin
        out_pix_q[k] <= gray_level(s1_hi_q[TileRows-1-k], low_rd_q[TileRows-1-k]);
      end
    end
  end

  assign pix_o.valid         = out_valid_q;
  assign pix_o.pixel_address = out_addr_q;
  assign pix_o.pixel_0       = out_pix_q[0];
  assign pix_o.pixel_1       = out_pix_q[1];
  assign pix_o.pixel_2       = out_pix_q[2];
  assign pix_o.pixel_3       = out_pix_q[3];
  assign pix_o.pixel_4       = out_pix_q[4];
  assign pix_o.pixel_5       = out_pix_q[5];
  assign pix_o.pixel_6       = out_pix_q[6];
  assign pix_o.pixel_7       = out_pix_q[7];

endmodule

@@ hdl/ptgr_checker.sv @@
// ----------------------------------------------------------------------------
// ptgr_checker
// Port-level checks for planar_tile_to_gray_raster, bound to the top level.
// ----------------------------------------------------------------------------
module ptgr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] out_addr_i,
  input logic [7:0]  out_pix0_i
);

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_addr_i) && $stable(out_pix0_i))
    else $error("output word changed while stalled");

  // empty output register never back-pressures the input
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output");

  // no word right after reset
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_i)
    else $error("output valid right after reset");

  // row addresses are always pixel-row aligned
  a_addr_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_addr_i[2:0] == 3'b000)
    else $error("misaligned pixel address");

endmodule

bind planar_tile_to_gray_raster ptgr_checker u_ptgr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (chr_i.ready),
  .out_valid_i (pix_o.valid),
  .out_ready_i (pix_o.ready),
  .out_addr_i  (pix_o.pixel_address),
  .out_pix0_i  (pix_o.pixel_0)
);

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Testbench for planar_tile_to_gray_raster. Random valid/ready traffic on the
// tile byte input and the gray row output, with a scoreboard that tracks the
// tile counters and the stored low-plane rows and checks each row word
// (address and eight gray levels) in order. Runs a directed tile, phases under
// several tiles_per_row settings and a final image with a back-to-back stretch.
// ----------------------------------------------------------------------------
module tb_top;
  import ptgr_pkg::*;

  localparam int unsigned MaxTiles      = MaxTilesDef;
  localparam int unsigned HoldCycles    = 400;
  localparam int unsigned SettleCycles  = 6;
  localparam int unsigned DrainLimit    = 200000;
  localparam int unsigned TimeoutCycles = 3000000;
  localparam int unsigned PhaseBytes    = 64;
  localparam int unsigned FinalBytes    = 80;
  localparam int unsigned MaxReports    = 200;

  localparam logic [1:0] PlaneNone = 2'b00;
  localparam logic [1:0] PlaneLow  = 2'b01;
  localparam logic [1:0] PlaneHigh = 2'b10;
  localparam logic [1:0] PlaneBoth = 2'b11;

  localparam pixel_t GrayNone = 8'h00;
  localparam pixel_t GrayLow  = 8'h55;
  localparam pixel_t GrayHigh = 8'haa;
  localparam pixel_t GrayBoth = 8'hff;

  typedef struct packed {
    logic [AddrW-1:0]        addr;
    logic [7:0][ByteW-1:0]   px;
  } gray_row_t;

  class gray_row_tracker;
    gray_row_t       rows_due[$];
    logic [TprW-1:0] cols_reg = TprReset;
    logic [ByteW-1:0] low_rows[TileRows];
    logic [3:0]      byte_idx = '0;
    logic [ColW-1:0] tile_col = '0;
    logic [AddrW-1:0] row_base = '0;
    logic [9:0]      tiles_done = '0;
    int unsigned     errors = 0;

    function void set_cols(logic [TprW-1:0] v);
      cols_reg = v;
    endfunction

    function int unsigned pending();
      return rows_due.size();
    endfunction

    function void fail_note();
      errors++;
    endfunction

    function void take_byte(logic [ByteW-1:0] data, logic new_image);
      int unsigned cols;
      int unsigned row;
      gray_row_t   w;
      logic [1:0]  code;
      cols = (cols_reg == 0) ? 1 : ((cols_reg > MaxCols) ? MaxCols : cols_reg);
      if (new_image) begin
        byte_idx = '0;
        tile_col = '0;
        row_base = '0;
        tiles_done = '0;
      end
      if (tiles_done >= MaxTiles) return;
      if (byte_idx < TileRows) begin
        low_rows[byte_idx[2:0]] = data;
        byte_idx++;
        return;
      end
      row = byte_idx[2:0];
      w.addr = AddrW'(row_base + 8 * tile_col + 8 * cols * row);
      for (int k = 0; k < 8; k++) begin
        code = {data[7-k], low_rows[row][7-k]};
        case (code)
          PlaneNone: w.px[k] = GrayNone;
          PlaneLow:  w.px[k] = GrayLow;
          PlaneHigh: w.px[k] = GrayHigh;
          default:   w.px[k] = GrayBoth;
        endcase
      end
      rows_due.push_back(w);
      if (byte_idx == TileBytes - 1) begin
        byte_idx = '0;
        tiles_done++;
        if (int'(tile_col) + 1 >= cols) begin
          tile_col = '0;
          row_base = AddrW'(row_base + 64 * cols);
        end else begin
          tile_col++;
        end
      end else begin
        byte_idx++;
      end
    endfunction

    function void check_row(logic [AddrW-1:0] addr, logic [7:0][ByteW-1:0] px);
      gray_row_t e;
      if (rows_due.size() == 0) begin
        errors++;
        if (errors <= MaxReports)
          $display("%0t: unexpected row word, expected none, actual addr %04h", $time, addr);
        return;
      end
      e = rows_due.pop_front();
      if (addr !== e.addr) begin
        errors++;
        if (errors <= MaxReports)
          $display("%0t: pixel_address mismatch, expected %04h actual %04h",
                   $time, e.addr, addr);
      end
      for (int k = 0; k < 8; k++) begin
        if (px[k] !== e.px[k]) begin
          errors++;
          if (errors <= MaxReports)
            $display("%0t: pixel_%0d mismatch at %04h, expected %02h actual %02h",
                     $time, k, e.addr, e.px[k], px[k]);
        end
      end
    endfunction
  endclass

  logic            clk_i = 1'b0;
  logic            rst_ni;
  logic            tpr_we;
  logic [TprW-1:0] tpr_val;
  bit              idle_on;
  bit              hold_req;

  gray_row_tracker sb;

  ptgr_in_if  chr_if ();
  ptgr_out_if pix_if ();

  planar_tile_to_gray_raster #(
    .MAX_TILES(MaxTiles)
  ) uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .tiles_per_row_we_i(tpr_we),
    .tiles_per_row_i   (tpr_val),
    .chr_i             (chr_if),
    .pix_o             (pix_if)
  );

  always #4 clk_i = ~clk_i;

  initial begin
    #(TimeoutCycles * 8);
    $display("Simulation FAILED");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (tpr_we) sb.set_cols(tpr_val);
      if (chr_if.valid && chr_if.ready) sb.take_byte(chr_if.chr_byte, chr_if.restart);
      if (pix_if.valid && pix_if.ready)
        sb.check_row(pix_if.pixel_address,
                     {pix_if.pixel_7, pix_if.pixel_6, pix_if.pixel_5, pix_if.pixel_4,
                      pix_if.pixel_3, pix_if.pixel_2, pix_if.pixel_1, pix_if.pixel_0});
    end
  end

  // output side backpressure
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    pix_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        stall_left = HoldCycles;
        hold_req = 1'b0;
      end else if (stall_left == 0 && idle_on && $urandom_range(0, 99) < 12) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(1, 3);
      end
      if (stall_left > 0) begin
        pix_if.ready <= 1'b0;
        stall_left--;
      end else begin
        pix_if.ready <= 1'b1;
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [ByteW-1:0] pick_byte();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return 8'h00;
    if (r < 20) return 8'hff;
    return ByteW'($urandom_range(0, 255));
  endfunction

  // entered and left at a falling edge
  task automatic send_byte(input logic [ByteW-1:0] data, input logic new_image);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      chr_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    chr_if.valid    <= 1'b1;
    chr_if.chr_byte <= data;
    chr_if.restart  <= new_image;
    do @(posedge clk_i); while (!chr_if.ready);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    int unsigned guard;
    chr_if.valid <= 1'b0;
    guard = 0;
    while (sb.pending() != 0 && guard < DrainLimit) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_cols(input logic [TprW-1:0] v);
    tpr_we  <= 1'b1;
    tpr_val <= v;
    @(negedge clk_i);
    tpr_we  <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic send_random(input int unsigned count);
    for (int unsigned i = 0; i < count; i++)
      send_byte(pick_byte(), $urandom_range(0, 99) < 2);
  endtask

  logic [ByteW-1:0] lo_rows_dir[TileRows] = '{8'h00, 8'hff, 8'h80, 8'h01,
                                              8'haa, 8'h55, 8'h0f, 8'hf0};
  logic [ByteW-1:0] hi_rows_dir[TileRows] = '{8'h00, 8'hff, 8'hff, 8'h01,
                                              8'h55, 8'haa, 8'hf0, 8'h0f};
  logic [TprW-1:0]  cols_set[8];

  initial begin
    sb = new;
    idle_on = 1'b1;
    hold_req = 1'b0;
    rst_ni = 1'b0;
    tpr_we = 1'b0;
    tpr_val = '0;
    chr_if.valid = 1'b0;
    chr_if.chr_byte = '0;
    chr_if.restart = 1'b0;
    cols_set = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd65, 7'h2a, 7'h55, 7'd1};
    cols_set[7] = TprW'($urandom_range(2, 63));
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // one tile with every plane combination, then restart mid-tile
    foreach (lo_rows_dir[i]) send_byte(lo_rows_dir[i], 1'b0);
    foreach (hi_rows_dir[i]) send_byte(hi_rows_dir[i], 1'b0);
    repeat (4) send_byte(pick_byte(), 1'b0);
    send_byte(8'h3c, 1'b1);
    wait_drained();

    // register changes mid-image, no restart between phases
    foreach (cols_set[p]) begin
      write_cols(cols_set[p]);
      idle_on = (p % 3 != 2);
      if (p == 1) hold_req = 1'b1;
      send_random(PhaseBytes);
      wait_drained();
    end

    // long image with a back-to-back stretch, then a new image
    idle_on = 1'b1;
    write_cols(7'd64);
    hold_req = 1'b1;
    send_byte(pick_byte(), 1'b1);
    for (int unsigned i = 1; i < FinalBytes; i++) begin
      if (i == FinalBytes / 2) idle_on = 1'b0;
      send_byte(pick_byte(), 1'b0);
    end
    idle_on = 1'b1;
    send_byte(pick_byte(), 1'b1);
    repeat (2 * TileBytes - 1) send_byte(pick_byte(), 1'b0);
    wait_drained();

    if (sb.pending() != 0) begin
      sb.fail_note();
      $display("%0t: %0d row words never arrived, first expected addr %04h",
               $time, sb.pending(), sb.rows_due[0].addr);
    end
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
hdl/ptgr_pkg.sv
hdl/ptgr_intf.sv
hdl/planar_tile_to_gray_raster.sv
hdl/ptgr_checker.sv
tb/tb_top.sv
